/* hdl/breath_flow_monitor_defines.svh */
// ----------------------------------------------------------------------------
// Breath flow monitor assertion macros
// Concurrent assertion helpers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BREATH_FLOW_MONITOR_DEFINES_SVH
`define BREATH_FLOW_MONITOR_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BFM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define BFM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BFM_ASSERT_IMP(lbl, ante, cons, msg)
`define BFM_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* hdl/bfm_pkg.sv */
// ----------------------------------------------------------------------------
// Breath flow monitor package
// Shared types, register indexes and constants.
// ----------------------------------------------------------------------------
package bfm_pkg;

  // configuration register indexes
  localparam logic [2:0] RegFlowLow  = 3'd0;
  localparam logic [2:0] RegFlowHigh = 3'd1;
  localparam logic [2:0] RegUnderLim = 3'd2;
  localparam logic [2:0] RegVolScale = 3'd3;
  localparam logic [2:0] RegMvLow    = 3'd4;
  localparam logic [2:0] RegMvHigh   = 3'd5;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;

  // reset values
  localparam logic signed [15:0] FlowLowRst  = 16'sd16;
  localparam logic signed [15:0] FlowHighRst = 16'sd160;
  localparam logic [7:0]         UnderLimRst = 8'd10;
  localparam logic [19:0]        VolScaleRst = 20'd33098;
  localparam logic [15:0]        MvLowRst    = 16'd500;
  localparam logic [15:0]        MvHighRst   = 16'd800;

  // rate = (60000 << 8) / dt, restoring divider
  localparam int unsigned         DivW     = 24;
  localparam logic [DivW-1:0]     RateNum  = 24'd15360000;
  localparam int unsigned         DivSteps = DivW;
  localparam int unsigned         DivCntW  = $clog2(DivSteps);

  // x / 5 for x < 2**23 as (x * ceil(2**25 / 5)) >> 25
  localparam int unsigned  MvShift = 25;
  localparam logic [22:0]  MvRecip = 23'd6710887;

  localparam logic [15:0]  Sat16   = 16'hFFFF;
  localparam logic [7:0]   CntMax  = 8'hFF;

  typedef struct packed {
    logic load;
    logic eval;
    logic acc;
    logic div_step;
    logic rate;
    logic mul1;
    logic mul2;
    logic mvchk;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic start;
  } status_t;

endpackage

/* hdl/bfm_ctrl.sv */
// ----------------------------------------------------------------------------
// Breath flow monitor controller
// Sequences one sample through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
module bfm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  bfm_pkg::status_t status_i,
  output bfm_pkg::cmd_t    cmd_o
);
  import bfm_pkg::*;

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StEval  = 9'b000000010,
    StAcc   = 9'b000000100,
    StDiv   = 9'b000001000,
    StRate  = 9'b000010000,
    StMul1  = 9'b000100000,
    StMul2  = 9'b001000000,
    StMvChk = 9'b010000000,
    StOut   = 9'b100000000
  } state_e;

  state_e               state_q, state_d;
  logic [DivCntW-1:0]   cnt_q, cnt_d;
  logic                 ovalid_q, ovalid_d;
  logic                 slot_free;

  assign slot_free   = !ovalid_q || out_ready_i;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ovalid_d = ovalid_q;
    cmd_o    = '0;
    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StEval;
        end
      end
      StEval: begin
        cmd_o.eval = 1'b1;
        state_d    = StAcc;
      end
      StAcc: begin
        cmd_o.acc = 1'b1;
        cnt_d     = '0;
        state_d   = status_i.start ? StDiv : StOut;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          state_d = StRate;
        end
      end
      StRate: begin
        cmd_o.rate = 1'b1;
        state_d    = StMul1;
      end
      StMul1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = StMul2;
      end
      StMul2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = StMvChk;
      end
      StMvChk: begin
        cmd_o.mvchk = 1'b1;
        state_d     = StOut;
      end
      StOut: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          ovalid_d       = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

/* hdl/bfm_datapath.sv */
// ----------------------------------------------------------------------------
// Breath flow monitor datapath
// Configuration, breath state, volume integrator, rate divider and
// minute volume check.
// ----------------------------------------------------------------------------
module bfm_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bfm_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [bfm_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic signed [15:0]               flow_sample_i,
  input  logic [31:0]                      timestamp_ms_i,
  input  bfm_pkg::cmd_t                    cmd_i,
  output bfm_pkg::status_t                 status_o,
  output logic [15:0]                      vol_ml_o,
  output logic [15:0]                      tidal_ml_o,
  output logic                             tidal_captured_o,
  output logic                             breath_start_o,
  output logic [15:0]                      rate_q8_o,
  output logic [15:0]                      minute_volume_cl_o,
  output logic                             volume_alarm_o
);
  import bfm_pkg::*;

  // configuration
  logic signed [15:0] lo_q, hi_q;
  logic [7:0]         lim_q;
  logic [19:0]        scale_q;
  logic [15:0]        mvlo_q, mvhi_q;

  // breath state
  logic [31:0]        acc_q;
  logic [15:0]        tidal_q;
  logic [7:0]         cnt_q;
  logic               armed_q;
  logic [31:0]        last_q;
  logic [15:0]        rate_q;
  logic [15:0]        mv_q;
  logic               alarm_q;

  // per-sample working registers
  logic signed [15:0] flow_q;
  logic [31:0]        time_q;
  logic signed [36:0] prod_q;
  logic               cap_q, start_q;
  logic [31:0]        dt_q;
  logic [31:0]        rem_q;
  logic [DivW-1:0]    dvd_q;
  logic [31:0]        mvp_q;
  logic [45:0]        rcp_q;

  // evaluation
  logic               inc, cap, armed_mid, hi_hit, start;
  logic [7:0]         cnt_inc;
  logic signed [36:0] prod_c;
  logic signed [32:0] delta;
  logic signed [33:0] sum;
  logic [31:0]        acc_new;
  logic [32:0]        trial, diff;
  logic               ge;
  logic [20:0]        mv_wide;
  logic [15:0]        mv_sat;

  assign inc       = armed_q && (flow_q < lo_q) && (cnt_q != CntMax);
  assign cnt_inc   = cnt_q + {7'd0, inc};
  assign cap       = armed_q && (cnt_inc > lim_q);
  assign armed_mid = armed_q && !cap;
  assign hi_hit    = flow_q > hi_q;
  assign start     = hi_hit && !armed_mid;

  assign prod_c = 37'(flow_q) * 37'(signed'({1'b0, scale_q}));
  assign delta  = prod_q[36:4];
  assign sum    = signed'({2'b00, acc_q}) + 34'(delta);

  always_comb begin
    if (sum[33]) begin
      acc_new = '0;
    end else if (sum[32]) begin
      acc_new = 32'hFFFF_FFFF;
    end else begin
      acc_new = sum[31:0];
    end
  end

  assign trial = {rem_q, dvd_q[DivW-1]};
  assign diff  = trial - {1'b0, dt_q};
  assign ge    = trial >= {1'b0, dt_q};

  assign mv_wide = rcp_q[45:MvShift];
  assign mv_sat  = (|mv_wide[20:16]) ? Sat16 : mv_wide[15:0];

  assign status_o.start = start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q    <= FlowLowRst;
      hi_q    <= FlowHighRst;
      lim_q   <= UnderLimRst;
      scale_q <= VolScaleRst;
      mvlo_q  <= MvLowRst;
      mvhi_q  <= MvHighRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegFlowLow:  lo_q    <= signed'(cfg_wdata_i[15:0]);
        RegFlowHigh: hi_q    <= signed'(cfg_wdata_i[15:0]);
        RegUnderLim: lim_q   <= cfg_wdata_i[7:0];
        RegVolScale: scale_q <= cfg_wdata_i;
        RegMvLow:    mvlo_q  <= cfg_wdata_i[15:0];
        RegMvHigh:   mvhi_q  <= cfg_wdata_i[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      tidal_q <= '0;
      cnt_q   <= '0;
      armed_q <= 1'b0;
      last_q  <= '0;
      rate_q  <= '0;
      mv_q    <= '0;
      alarm_q <= 1'b0;
      start_q <= 1'b0;
    end else begin
      if (cmd_i.eval) begin
        start_q <= start;
        armed_q <= armed_mid || hi_hit;
        if (cap) begin
          cnt_q   <= '0;
          tidal_q <= acc_q[31:16];
          acc_q   <= '0;
        end else begin
          cnt_q   <= cnt_inc;
        end
        if (start) begin
          last_q <= time_q;
        end
      end
      if (cmd_i.acc) begin
        acc_q <= acc_new;
      end
      if (cmd_i.rate) begin
        rate_q <= (|dvd_q[DivW-1:16]) ? Sat16 : dvd_q[15:0];
      end
      if (cmd_i.mvchk) begin
        mv_q    <= mv_sat;
        alarm_q <= !((mv_sat > mvlo_q) && (mv_sat < mvhi_q));
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      flow_q <= flow_sample_i;
      time_q <= timestamp_ms_i;
    end
    if (cmd_i.eval) begin
      prod_q <= prod_c;
      cap_q  <= cap;
      dt_q   <= time_q - last_q;
      rem_q  <= '0;
      dvd_q  <= RateNum;
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? diff[31:0] : trial[31:0];
      dvd_q <= {dvd_q[DivW-2:0], ge};
    end
    if (cmd_i.mul1) begin
      mvp_q <= 32'(rate_q) * 32'(tidal_q);
    end
    if (cmd_i.mul2) begin
      rcp_q <= 46'(mvp_q[31:9]) * 46'(MvRecip);
    end
    if (cmd_i.out_load) begin
      vol_ml_o           <= acc_q[31:16];
      tidal_ml_o         <= tidal_q;
      tidal_captured_o   <= cap_q;
      breath_start_o     <= start_q;
      rate_q8_o          <= rate_q;
      minute_volume_cl_o <= mv_q;
      volume_alarm_o     <= alarm_q;
    end
  end

endmodule

/* hdl/breath_flow_monitor.sv */
// ----------------------------------------------------------------------------
// Breath flow monitor
// Expired volume integrator, breath detector, rate and minute volume alarm.
// ----------------------------------------------------------------------------
// One result per flow sample. A sample that does not start a breath passes
// through load, evaluation, accumulation and output; a breath start also
// passes through the divider and the later steps before output: the rate is
// worked out by a 24-step restoring divider, one quotient bit per cycle, then
// saturated, followed by two registered multiplies for the minute volume and
// the alarm check. One sample is in flight at a time; the next is taken as
// soon as the previous result sits in the output register. A result left
// waiting there holds the following sample in its last cycle until the
// output beat is taken.
`include "breath_flow_monitor_defines.svh"

module breath_flow_monitor (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bfm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bfm_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [15:0]           flow_sample_i,
  input  logic [31:0]                  timestamp_ms_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [15:0]                  vol_ml_o,
  output logic [15:0]                  tidal_ml_o,
  output logic                         tidal_captured_o,
  output logic                         breath_start_o,
  output logic [15:0]                  rate_q8_o,
  output logic [15:0]                  minute_volume_cl_o,
  output logic                         volume_alarm_o
);
  import bfm_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    cap_beat;
  logic    start_no_alarm;

  bfm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bfm_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .flow_sample_i      (flow_sample_i),
    .timestamp_ms_i     (timestamp_ms_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .vol_ml_o           (vol_ml_o),
    .tidal_ml_o         (tidal_ml_o),
    .tidal_captured_o   (tidal_captured_o),
    .breath_start_o     (breath_start_o),
    .rate_q8_o          (rate_q8_o),
    .minute_volume_cl_o (minute_volume_cl_o),
    .volume_alarm_o     (volume_alarm_o)
  );

  assign cap_beat       = out_valid_o && tidal_captured_o;
  assign start_no_alarm = out_valid_o && breath_start_o && !volume_alarm_o;

  // one sample in flight: an accepted beat closes the input until its result
  `BFM_ASSERT_NXT(a_single_item, in_valid_i && in_ready_o, !in_ready_o, "second beat taken early")
  // volume was cleared on capture, so at most one sample's worth remains
  `BFM_ASSERT_IMP(a_capture_clears, cap_beat, !vol_ml_o[15], "volume not cleared on capture")
  // no alarm means minute volume lies above a non-negative limit
  `BFM_ASSERT_IMP(a_alarm_mv, start_no_alarm, minute_volume_cl_o != 16'd0, "alarm clear, mv zero")

endmodule
